[rtl/bcr_pkg.sv]
// Shared constants, types and helper functions of the audio bitcrusher.
package bcr_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int PHASE_W      = 15;
  localparam int LEVEL_W      = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int MUL_W        = 18;
  localparam int PROD_W       = 2 * MUL_W;
  localparam int WIDE_W       = 38;
  localparam int NUM_CHANNELS_DEF = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_CRUSH_BITS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_PERIOD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_LEVEL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WET_MIX     = 2'd3;

  localparam logic [4:0]         BITS_FULL  = 5'd16;
  localparam logic [4:0]         BITS_QMAX  = 5'd14;
  localparam logic [PHASE_W-1:0] UNITY      = 15'd256;
  localparam logic [PHASE_W-1:0] PERIOD_MAX = 15'd25856;
  localparam logic [16:0]        Q15_ONE    = 17'd32768;
  localparam logic [31:0]        SEED_BASE  = 32'd12345;
  localparam logic [31:0]        SEED_STEP  = 32'd55545;

  typedef struct packed {
    logic signed [MUL_W-1:0] a;
    logic signed [MUL_W-1:0] b;
  } mul_op_t;

  // Saturate a wide signed value to the Q1.15 range.
  function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [WIDE_W-1:0] v);
    logic signed [SAMPLE_W-1:0] r;
    if (v > 38'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -38'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

  // One xorshift32 step.
  function automatic logic [31:0] next_rand(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x << 13);
    y = y ^ (y >> 17);
    y = y ^ (y << 5);
    return y;
  endfunction

  // Seed of a channel after reset.
  function automatic logic [31:0] seed_init(input int k);
    return SEED_BASE + SEED_STEP * 32'(k);
  endfunction

endpackage

[rtl/audio_bitcrusher.sv]
// Top level of the audio bitcrusher: sequencer, channel state and output register.
//
// The input channel (in_*) carries one signed Q1.15 sample in in_tdata and its
// channel number in in_tuser. Each accepted transaction yields exactly one
// result transaction on the output channel (out_*), a saturated Q1.15 sample.
// The processing runs through sample-and-hold, bit-depth rounding, noise
// injection and a dry/wet blend, all on one shared registered multiplier.
// After acceptance an item passes the sequencer steps prep, amount, noise,
// dry, wet and output; the multiplier, used four times per item, is why no
// new transaction is taken before it is done. in_tready is high only while the
// sequencer is idle. The result sits in an output register; while the
// receiver stalls, the finished item waits there and the next input can
// already be taken. A second finished item holds the sequencer in its last
// step, with in_tready low, until the register frees.
// The configuration port writes one register per cycle with cfg_we high; it
// is to be written only while no item is in flight.
// Reset (synchronous, active low) restores the register defaults, clears the
// held samples and phase accumulators, loads the noise seeds and drops
// out_tvalid.
module audio_bitcrusher
  import bcr_pkg::*;
#(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [15:0]           in_tdata,   // [15:0] sample_in
  input  logic [0:0]            in_tuser,   // [0] chan
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [15:0]           out_tdata,  // [15:0] sample_out
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_AMT, S_NOISE, S_DRY, S_WET, S_OUT
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [4:0]          crush_r;
  logic [PHASE_W-1:0]  hold_r;
  logic [LEVEL_W-1:0]  level_r;
  logic [LEVEL_W-1:0]  mix_r;

  // Per-channel state.
  logic signed [SAMPLE_W-1:0] held_r  [NUM_CHANNELS];
  logic [PHASE_W-1:0]         phase_r [NUM_CHANNELS];
  logic [31:0]                seed_r  [NUM_CHANNELS];

  // Working registers of the item in flight.
  logic signed [SAMPLE_W-1:0] dry_r;
  logic [CH_W-1:0]            ch_r;
  logic signed [SAMPLE_W-1:0] x_r;
  logic signed [PROD_W-1:0]   acc_r;
  logic                       out_valid_r;
  logic [SAMPLE_W-1:0]        out_data_r;

  // Clamped register values.
  logic [4:0]         bits_c;
  logic [PHASE_W-1:0] per_c;
  logic [16:0]        lvl_c;
  logic [16:0]        mix_c;
  logic               hold_on;

  always_comb begin
    if (crush_r == 5'd0) begin
      bits_c = 5'd1;
    end else if (crush_r > BITS_FULL) begin
      bits_c = BITS_FULL;
    end else begin
      bits_c = crush_r;
    end
    if (hold_r < UNITY) begin
      per_c = UNITY;
    end else if (hold_r > PERIOD_MAX) begin
      per_c = PERIOD_MAX;
    end else begin
      per_c = hold_r;
    end
    lvl_c   = ({1'b0, level_r} > Q15_ONE) ? Q15_ONE : {1'b0, level_r};
    mix_c   = ({1'b0, mix_r} > Q15_ONE) ? Q15_ONE : {1'b0, mix_r};
    hold_on = per_c > UNITY;
  end

  logic in_acc;
  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);

  logic [CH_W-1:0] in_ch;
  assign in_ch = (NUM_CHANNELS > 1) ? CH_W'(in_tuser[0]) : '0;

  // Sample-and-hold: the phase advances by UNITY per sample and the input is
  // captured when it reaches the period.
  logic [PHASE_W-1:0]         phase_adv;
  logic                       take;
  logic signed [SAMPLE_W-1:0] hx;

  assign phase_adv = phase_r[ch_r] + UNITY;
  assign take      = phase_adv >= per_c;
  assign hx        = (hold_on && !take) ? held_r[ch_r] : dry_r;

  // Rounding quantizer: add half a step, then clear the bits below the step.
  logic [3:0]                 qs;
  logic [17:0]                q_half;
  logic [17:0]                q_mask;
  logic [17:0]                q_sum;
  logic signed [SAMPLE_W-1:0] qx;

  always_comb begin
    qs     = 4'(5'd15 - bits_c);
    q_half = 18'd1 << (qs - 4'd1);
    q_mask = ~((18'd1 << qs) - 18'd1);
    q_sum  = 18'(hx) + q_half;
    if (bits_c <= BITS_QMAX) begin
      qx = sat16(WIDE_W'($signed(q_sum & q_mask)));
    end else begin
      qx = hx;
    end
  end

  logic [31:0] seed_nxt;
  assign seed_nxt = next_rand(seed_r[ch_r]);

  // Shared multiplier and its operand selection.
  mul_op_t                  mop;
  logic signed [PROD_W-1:0] prod;

  bcr_mul u_mul (
    .clk  (clk),
    .op   (mop),
    .prod (prod)
  );

  logic signed [16:0] noise_n;
  logic signed [16:0] mag;
  logic [16:0]        wet_dry;

  assign noise_n = $signed({1'b0, seed_r[ch_r][31:16]}) - 17'sd32768;
  assign mag     = x_r[SAMPLE_W-1] ? -17'(x_r) : 17'(x_r);
  assign wet_dry = Q15_ONE - mix_c;

  // The output step keeps the wet operands so the product stays valid while
  // the step waits for the output register.
  always_comb begin
    unique case (state_r)
      S_AMT: begin
        mop.a = $signed({1'b0, lvl_c});
        mop.b = MUL_W'(mag);
      end
      S_NOISE: begin
        mop.a = MUL_W'(noise_n);
        mop.b = $signed({3'b000, prod[30:16]});
      end
      S_DRY: begin
        mop.a = MUL_W'(dry_r);
        mop.b = $signed({1'b0, wet_dry});
      end
      S_WET, S_OUT: begin
        mop.a = MUL_W'(x_r);
        mop.b = $signed({1'b0, mix_c});
      end
      default: begin
        mop.a = '0;
        mop.b = '0;
      end
    endcase
  end

  // Noise add and final blend, both rounded half up before the shift.
  logic signed [WIDE_W-1:0] noise_add;
  logic signed [WIDE_W-1:0] blend;

  assign noise_add = WIDE_W'(x_r) + ((WIDE_W'(prod) + 38'sd16384) >>> 15);
  assign blend     = (WIDE_W'(acc_r) + WIDE_W'(prod) + 38'sd16384) >>> 15;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      crush_r     <= BITS_FULL;
      hold_r      <= UNITY;
      level_r     <= '0;
      mix_r       <= Q15_ONE[LEVEL_W-1:0];
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        held_r[k]  <= '0;
        phase_r[k] <= '0;
        seed_r[k]  <= seed_init(k);
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_CRUSH_BITS:  crush_r <= cfg_wdata[4:0];
          CFG_HOLD_PERIOD: hold_r  <= cfg_wdata[PHASE_W-1:0];
          CFG_NOISE_LEVEL: level_r <= cfg_wdata;
          CFG_WET_MIX:     mix_r   <= cfg_wdata;
          default: ;
        endcase
      end

      // The output step sets the valid flag itself.
      if (out_valid_r && out_tready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            dry_r   <= $signed(in_tdata);
            ch_r    <= in_ch;
            state_r <= S_PREP;
          end
        end
        S_PREP: begin
          if (hold_on) begin
            phase_r[ch_r] <= take ? (phase_adv - per_c) : phase_adv;
            if (take) begin
              held_r[ch_r] <= dry_r;
            end
          end
          if (lvl_c != 17'd0) begin
            seed_r[ch_r] <= seed_nxt;
          end
          x_r     <= qx;
          state_r <= S_AMT;
        end
        S_AMT: begin
          state_r <= S_NOISE;
        end
        S_NOISE: begin
          state_r <= S_DRY;
        end
        S_DRY: begin
          if (lvl_c != 17'd0) begin
            x_r <= sat16(noise_add);
          end
          state_r <= S_WET;
        end
        S_WET: begin
          acc_r   <= prod;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_data_r  <= sat16(blend);
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A new result appears only out of the last sequencer step.
  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result raised outside the output step");

  // Once an item is taken, the block is busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_PREP) && !in_tready)
    else $error("sequencer did not start after an accepted item");

  // With noise off, the channel's seed does not advance.
  a_seed_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PREP) && (lvl_c == 17'd0) |=> $stable(seed_r[ch_r]))
    else $error("noise seed advanced with noise disabled");

  // Xorshift never reaches the all-zero state from a nonzero seed.
  for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_seed_chk
    a_seed_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
      $past(rst_n) |-> (seed_r[g] != 32'd0))
      else $error("noise seed collapsed to zero");
  end

endmodule

[rtl/bcr_mul.sv]
// Shared signed 18x18 multiplier with a registered product.
module bcr_mul
  import bcr_pkg::*;
(
  input  logic                     clk,
  input  mul_op_t                  op,
  output logic signed [PROD_W-1:0] prod
);

  logic signed [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= op.a * op.b;
  end

  assign prod = prod_r;

endmodule

[test/audio_bitcrusher_tb.sv]
// Self-checking testbench of the audio bitcrusher: stream stimulus, predictor and result checks.
module audio_bitcrusher_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bcr_pkg::*;

  // The run is stopped as failed if it is still going after this many cycles.
  // The slowest correct run is far below it: about 600 transactions, each
  // needing its pass through the block plus sender gaps and receiver stalls.
  localparam int CYCLE_LIMIT  = 200_000;
  // Cycles to let pass once the last expected result has arrived, before a
  // register write and before the final verdict.
  localparam int IDLE_SETTLE  = 8;
  localparam int FINAL_SETTLE = 20;
  // Length of the long receiver hold-off that makes the block back up.
  localparam int LONG_STALL   = 300;

  typedef enum int {TX_STREAM, TX_BURSTY} tx_mode_t;
  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

  // Clock, reset and every block input start at known values.
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [15:0]           in_tdata = '0;   // [15:0] sample_in
  logic [0:0]            in_tuser = '0;   // [0] chan
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [15:0]           out_tdata;       // [15:0] sample_out
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  always #5 clk = ~clk;

  audio_bitcrusher #(
    .NUM_CHANNELS(2)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: a shadow copy of the registers and of the per-channel
  // sample-and-hold, phase accumulator and noise generator.
  // ---------------------------------------------------------------------------
  logic [4:0]  depth_cfg;
  logic [14:0] period_cfg;
  logic [15:0] level_cfg;
  logic [15:0] wet_cfg;

  logic [15:0] hold_val   [2];
  logic [14:0] hold_phase [2];
  logic [31:0] lfsr_state [2];

  // Expected crushed samples, oldest first, one per accepted input transaction.
  logic [15:0] crushed_q [$];
  logic [15:0] next_expected;
  int          n_fail = 0;

  // Stimulus pacing controls, written only by the test sequence.
  tx_mode_t tx_mode = TX_STREAM;
  rx_mode_t rx_mode = RX_ALWAYS;
  int       burst_left = 0;
  int       stall_req = 0;

  // Receiver-side bookkeeping, written only by the receiver and watchdog processes.
  int       stall_seen = 0;
  int       stall_left = 0;
  int       rx_tick = 0;
  int       cycle_cnt = 0;

  // Put the shadow state into its post-reset condition.
  function automatic void reset_shadow();
    depth_cfg  = BITS_FULL;
    period_cfg = UNITY;
    level_cfg  = '0;
    wet_cfg    = Q15_ONE[15:0];
    for (int k = 0; k < 2; k++) begin
      hold_val[k]   = '0;
      hold_phase[k] = '0;
    end
    lfsr_state[0] = 32'd12345;
    lfsr_state[1] = 32'd67890;
  endfunction

  function automatic longint clip16(input longint v);
    return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
  endfunction

  // Work out the crushed sample for one input transaction and advance the
  // channel state the way the block does. Arithmetic right shifts of signed
  // values give the floor division that the fixed-point format calls for.
  function automatic logic [15:0] crush_predict(input logic [15:0] smp, input logic [0:0] ch);
    longint      dry, x, q, n, mag, amt;
    int          depth, per, lvl, wet, sh;
    logic [14:0] ph;
    logic [31:0] r;
    dry   = longint'($signed(smp));
    depth = (depth_cfg < 1) ? 1 : ((depth_cfg > 16) ? 16 : int'(depth_cfg));
    per   = (period_cfg < UNITY) ? int'(UNITY) :
            ((period_cfg > PERIOD_MAX) ? int'(PERIOD_MAX) : int'(period_cfg));
    lvl   = (level_cfg > Q15_ONE) ? int'(Q15_ONE) : int'(level_cfg);
    wet   = (wet_cfg > Q15_ONE) ? int'(Q15_ONE) : int'(wet_cfg);
    x     = dry;

    // Sample-and-hold: the phase wraps at the period, where the held sample reloads.
    if (per > int'(UNITY)) begin
      ph = hold_phase[ch] + UNITY;
      if (ph >= per) begin
        hold_val[ch] = smp;
        ph = ph - per;
      end
      hold_phase[ch] = ph;
      x = longint'($signed(hold_val[ch]));
    end

    // Round to the bit depth; at 15 bits and up nothing changes.
    if (depth < 15) begin
      sh = 15 - depth;
      q  = (x + (longint'(1) << (sh - 1))) >>> sh;
      x  = clip16(q * (longint'(1) << sh));
    end

    // Noise scaled by the level and half the signal magnitude.
    if (lvl > 0) begin
      r = lfsr_state[ch];
      r = r ^ (r << 13);
      r = r ^ (r >> 17);
      r = r ^ (r << 5);
      lfsr_state[ch] = r;
      n   = longint'(r[31:16]) - 32768;
      mag = (x < 0) ? -x : x;
      amt = (longint'(lvl) * mag) >>> 16;
      x   = clip16(x + ((n * amt + 16384) >>> 15));
    end

    x = clip16((dry * longint'(32768 - wet) + x * longint'(wet) + 16384) >>> 15);
    return x[15:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: stalls on its own pattern, and on request holds off for a long
  // stretch that it counts itself.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_req != stall_seen) begin
      stall_seen <= stall_req;
      stall_left <= LONG_STALL;
      out_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS: begin
          out_tready <= 1'b1;
        end
        RX_RANDOM: begin
          out_tready <= ($urandom_range(0, 3) != 0);
        end
        default: begin
          // Low while the tick count modulo 11 is below 4, so the stall drifts across
          // the rhythm of the block's sequencer steps.
          out_tready <= ((rx_tick % 11) >= 4);
        end
      endcase
    end
  end

  // Each result transaction is matched against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (crushed_q.size() == 0) begin
        $error("sample_out: result %0d arrived with no expectation pending",
               $signed(out_tdata));
        n_fail++;
      end else begin
        next_expected = crushed_q.pop_front();
        if (out_tdata !== next_expected) begin
          $error("sample_out: expected %0d, actual %0d",
                 $signed(next_expected), $signed(out_tdata));
          n_fail++;
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared stimulus tasks.
  // ---------------------------------------------------------------------------

  // After a transaction, the bursty sender may drop tvalid for a random gap.
  task automatic pace_sender();
    int gap;
    if (tx_mode == TX_BURSTY) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = $urandom_range(1, 15);
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Offer one sample until the block takes it, then record its expectation.
  // Except after a bursty gap, tvalid stays high on return so back-to-back transactions need no gap.
  task automatic send_sample(input logic [15:0] smp, input logic [0:0] ch);
    in_tvalid <= 1'b1;
    in_tdata  <= smp;
    in_tuser  <= ch;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    crushed_q.push_back(crush_predict(smp, ch));
    pace_sender();
  endtask

  // Stop offering, wait for every expected result, then let the block settle.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (crushed_q.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  // One register write, followed by a quiet cycle so writes never touch.
  task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_CRUSH_BITS:  depth_cfg  = val[4:0];
      CFG_HOLD_PERIOD: period_cfg = val[14:0];
      CFG_NOISE_LEVEL: level_cfg  = val;
      default:         wet_cfg    = val;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Random register value, with the clamped and bypass settings well represented.
  function automatic logic [15:0] random_setting(input logic [CFG_IDX_W-1:0] idx);
    logic [15:0] v;
    case (idx)
      CFG_CRUSH_BITS: begin
        case ($urandom_range(0, 9))
          0:       v = 16'd0;
          1:       v = 16'd1;
          2:       v = 16'd16;
          3:       v = 16'($urandom_range(17, 31));
          4:       v = 16'($urandom_range(0, 65535));
          default: v = 16'($urandom_range(2, 15));
        endcase
      end
      CFG_HOLD_PERIOD: begin
        // Mostly short periods so the held sample is refreshed often.
        case ($urandom_range(0, 9))
          0:       v = 16'($urandom_range(0, 255));
          1:       v = 16'd256;
          2:       v = 16'd25856;
          3:       v = 16'($urandom_range(25857, 32767));
          4:       v = 16'($urandom_range(32768, 65535));
          default: v = 16'($urandom_range(257, 1024));
        endcase
      end
      default: begin
        // Noise level and wet mix share the same shape of range.
        case ($urandom_range(0, 7))
          0:       v = 16'd0;
          1:       v = 16'd32768;
          2:       v = 16'($urandom_range(32769, 65535));
          default: v = 16'($urandom_range(1, 32767));
        endcase
      end
    endcase
    return v;
  endfunction

  // Random sample: occasionally a full-scale or near-zero value.
  function automatic logic [15:0] random_sample();
    logic [15:0] v;
    case ($urandom_range(0, 11))
      0:       v = 16'h8000;
      1:       v = 16'h7FFF;
      2:       v = 16'h0000;
      3:       v = 16'hFFFF;
      default: v = 16'($urandom_range(0, 65535));
    endcase
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Test tasks.
  // ---------------------------------------------------------------------------

  // With the reset settings the block is a straight wire: every effect is off
  // and the mix is fully wet.
  task automatic test_reset_defaults();
    tx_mode = TX_STREAM;
    rx_mode = RX_ALWAYS;
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7FFF, 1'b1);
    send_sample(16'h0000, 1'b0);
    send_sample(16'hFFFF, 1'b1);
    send_sample(16'h0001, 1'b0);
    send_sample(16'h4000, 1'b1);
    wait_idle();
  endtask

  // One-bit rounding pushes full scale past +1.0 into saturation; a depth of
  // zero acts as one bit, and depths above 16 bypass.
  task automatic test_bit_depth();
    set_register(CFG_CRUSH_BITS, 16'd1);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b1);
    send_sample(16'hC000, 1'b0);
    wait_idle();
    set_register(CFG_CRUSH_BITS, 16'd0);
    send_sample(16'h3FFF, 1'b1);
    wait_idle();
    // All ones leaves 31 in the five-bit register, which acts as no rounding.
    set_register(CFG_CRUSH_BITS, 16'hFFFF);
    send_sample(16'h1234, 1'b0);
    wait_idle();
    set_register(CFG_CRUSH_BITS, 16'd16);
  endtask

  // A period of two samples holds every other input; periods below unity
  // bypass the hold and periods above the maximum clamp to it.
  task automatic test_sample_hold();
    set_register(CFG_HOLD_PERIOD, 16'd512);
    send_sample(16'h1111, 1'b0);
    send_sample(16'h2222, 1'b0);
    send_sample(16'hDDDD, 1'b1);
    wait_idle();
    set_register(CFG_HOLD_PERIOD, 16'd100);
    send_sample(16'h5555, 1'b0);
    wait_idle();
    set_register(CFG_HOLD_PERIOD, 16'd32767);
    send_sample(16'hAAAA, 1'b1);
    wait_idle();
    set_register(CFG_HOLD_PERIOD, 16'd256);
  endtask

  // A level above one clamps to full noise, layered over an 8-bit depth;
  // a zero sample must stay noiseless since the noise scales with magnitude.
  task automatic test_noise();
    set_register(CFG_NOISE_LEVEL, 16'hFFFF);
    set_register(CFG_CRUSH_BITS, 16'd8);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b1);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h5A5A, 1'b1);
    wait_idle();
    set_register(CFG_NOISE_LEVEL, 16'd0);
    set_register(CFG_CRUSH_BITS, 16'd16);
  endtask

  // Dry only, an even blend, and a mix above one that clamps to fully wet,
  // with coarse rounding so wet and dry differ.
  task automatic test_wet_mix();
    set_register(CFG_CRUSH_BITS, 16'd4);
    set_register(CFG_WET_MIX, 16'd0);
    send_sample(16'h1357, 1'b0);
    wait_idle();
    set_register(CFG_WET_MIX, 16'd16384);
    send_sample(16'h7FFF, 1'b1);
    send_sample(16'h8001, 1'b0);
    wait_idle();
    set_register(CFG_WET_MIX, 16'hFFFF);
    send_sample(16'h2468, 1'b1);
    wait_idle();
    set_register(CFG_WET_MIX, 16'd32768);
    set_register(CFG_CRUSH_BITS, 16'd16);
  endtask

  // Random samples across a series of random settings. The first phase uses
  // every effect at its strongest; each phase draws its own pacing.
  task automatic test_random_settings(input int phases, input int per_phase);
    for (int p = 0; p < phases; p++) begin
      if (p == 0) begin
        set_register(CFG_CRUSH_BITS, 16'd1);
        set_register(CFG_HOLD_PERIOD, 16'd25856);
        set_register(CFG_NOISE_LEVEL, 16'd32768);
        set_register(CFG_WET_MIX, 16'd32768);
      end else begin
        for (int r = 0; r < 4; r++) begin
          set_register(r[CFG_IDX_W-1:0], random_setting(r[CFG_IDX_W-1:0]));
        end
      end
      tx_mode = tx_mode_t'($urandom_range(0, 1));
      rx_mode = rx_mode_t'($urandom_range(0, 2));
      for (int i = 0; i < per_phase; i++) begin
        send_sample(random_sample(), 1'($urandom_range(0, 1)));
      end
      wait_idle();
    end
  endtask

  // The receiver holds off for a long stretch while the sender streams, so
  // the output register and the sequencer fill and the input must stall.
  task automatic test_backpressure(input int count);
    for (int r = 0; r < 4; r++) begin
      set_register(r[CFG_IDX_W-1:0], random_setting(r[CFG_IDX_W-1:0]));
    end
    tx_mode = TX_STREAM;
    rx_mode = RX_ALWAYS;
    stall_req++;
    for (int i = 0; i < count; i++) begin
      send_sample(random_sample(), 1'($urandom_range(0, 1)));
    end
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    reset_shadow();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_bit_depth();
    test_sample_hold();
    test_noise();
    test_wet_mix();
    test_random_settings(8, 62);
    test_backpressure(48);

    while (crushed_q.size() != 0) @(posedge clk);
    repeat (FINAL_SETTLE) @(posedge clk);
    if (n_fail == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[audio_bitcrusher.f]
rtl/bcr_pkg.sv
rtl/bcr_mul.sv
rtl/audio_bitcrusher.sv
test/audio_bitcrusher_tb.sv
